[hdl/playfair_pair_encryptor_core_assert.svh]
// Assertion macros for the Playfair pair encryptor.
// Included by the top level; no other dependencies.
`ifndef PLAYFAIR_PAIR_ENCRYPTOR_CORE_ASSERT_SVH
`define PLAYFAIR_PAIR_ENCRYPTOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PPE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppe assertion failed");
`define PPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppe assertion failed");
`else
`define PPE_ASSERT_SAME(label, clk, rst, ante, cons)
`define PPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/ppe_pkg.sv]
// Shared types, constants and helper functions for the Playfair pair encryptor.
// No dependencies.
package ppe_pkg;

   localparam int LETTER_W     = 5;
   localparam int CELL_COUNT   = 25;
   localparam int SIDE         = 5;
   localparam int COORD_W      = 3;
   localparam int IDX_W        = 5;
   localparam int CSR_DATA_W   = 45;
   localparam int CSR_INDEX_W  = 2;
   localparam int FIRST_W      = 45;
   localparam int MIDDLE_W     = 40;
   localparam int FINAL_W      = 40;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
   localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;

   localparam logic [FIRST_W-1:0]  FIRST_RESET  = 45'd1103318704266;
   localparam logic [MIDDLE_W-1:0] MIDDLE_RESET = 40'd459939223714;
   localparam logic [FINAL_W-1:0]  FINAL_RESET  = 40'd884415777295;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CELLS_FIRST  = 2'd0,
      CSR_CELLS_MIDDLE = 2'd1,
      CSR_CELLS_FINAL  = 2'd2
   } csr_index_type;

   typedef logic [CELL_COUNT-1:0][LETTER_W-1:0] square_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                end_of_message;
   } req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first_cipher;
      logic [LETTER_W-1:0] second_cipher;
      logic                final_pair;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } pos_type;

   typedef struct packed {
      pos_type first_pos;
      pos_type second_pos;
      logic    final_pair;
   } pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic held_valid;
   } front_status_type;

   // first match in row-major order, cell 0 when absent
   function automatic pos_type locate(input square_type sq, input logic [LETTER_W-1:0] ch);
      pos_type pos;
      pos = '0;
      for (int r = SIDE - 1; r >= 0; r--) begin
         for (int c = SIDE - 1; c >= 0; c--) begin
            if (sq[r * SIDE + c] == ch) begin
               pos.row = COORD_W'(r);
               pos.col = COORD_W'(c);
            end
         end
      end
      return pos;
   endfunction

   function automatic logic [COORD_W-1:0] next_coord(input logic [COORD_W-1:0] x);
      logic [COORD_W-1:0] y;
      y = (x == COORD_W'(SIDE - 1)) ? '0 : x + COORD_W'(1);
      return y;
   endfunction

   function automatic logic [IDX_W-1:0] cell_index(input pos_type p);
      logic [IDX_W-1:0] idx;
      idx = {p.row, 2'b00} + IDX_W'(p.row) + IDX_W'(p.col);
      return idx;
   endfunction

endpackage

[hdl/ppe_front.sv]
// Front end: J-to-I mapping, pending first letter, pair forming and cell lookup.
// Depends on ppe_pkg.
module ppe_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_accept,
   input  ppe_pkg::req_type          req_data,
   input  ppe_pkg::square_type       square,
   output logic                      push,
   output ppe_pkg::pair_type         push_data,
   output ppe_pkg::front_status_type status
);

   logic                         held_valid_ff, held_valid_in;
   logic [ppe_pkg::LETTER_W-1:0] held_letter_ff, held_letter_in;
   logic [ppe_pkg::LETTER_W-1:0] ch, a, b, b_fix;
   logic                         emit;

   always_comb begin
      ch   = (req_data.letter == ppe_pkg::LETTER_J) ? ppe_pkg::LETTER_I : req_data.letter;
      emit = held_valid_ff || req_data.end_of_message;
      a    = held_valid_ff ? held_letter_ff : ch;
      b    = held_valid_ff ? ch : ppe_pkg::LETTER_X;
      b_fix = (a == b) ? ppe_pkg::LETTER_X : b;

      push                 = req_accept && emit;
      push_data.first_pos  = ppe_pkg::locate(square, a);
      push_data.second_pos = ppe_pkg::locate(square, b_fix);
      push_data.final_pair = req_data.end_of_message;

      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      if (req_accept) begin
         held_valid_in = !emit;
         if (!emit) begin
            held_letter_in = ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
      held_letter_ff <= held_letter_in;
   end

   assign status.held_valid = held_valid_ff;

endmodule

[hdl/ppe_queue.sv]
// Short register queue carrying located pairs from front to back end.
// Depends on ppe_pkg.
module ppe_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ppe_pkg::pair_type         push_data,
   input  logic                      pop,
   output ppe_pkg::pair_type         pop_data,
   output ppe_pkg::queue_status_type status
);

   ppe_pkg::pair_type                entry_ff [ppe_pkg::QUEUE_DEPTH];
   logic [ppe_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ppe_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ppe_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ppe_pkg::QUEUE_PTR_W'(ppe_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ppe_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ppe_pkg::QUEUE_PTR_W'(ppe_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ppe_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + ppe_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - ppe_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == ppe_pkg::QUEUE_CNT_W'(ppe_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[hdl/ppe_back.sv]
// Back end: row, column and rectangle rules, cell read-out and output register.
// Depends on ppe_pkg.
module ppe_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ppe_pkg::square_type       square,
   input  ppe_pkg::pair_type         pair,
   input  ppe_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ppe_pkg::rsp_type          rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   ppe_pkg::rsp_type rsp_data_ff, rsp_data_in;
   ppe_pkg::pos_type pa, pb, qa, qb;

   always_comb begin
      pa = pair.first_pos;
      pb = pair.second_pos;
      if (pa.row == pb.row) begin
         qa = '{row: pa.row, col: ppe_pkg::next_coord(pa.col)};
         qb = '{row: pb.row, col: ppe_pkg::next_coord(pb.col)};
      end else if (pa.col == pb.col) begin
         qa = '{row: ppe_pkg::next_coord(pa.row), col: pa.col};
         qb = '{row: ppe_pkg::next_coord(pb.row), col: pb.col};
      end else begin
         qa = '{row: pa.row, col: pb.col};
         qb = '{row: pb.row, col: pa.col};
      end

      pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.first_cipher  = square[ppe_pkg::cell_index(qa)];
         rsp_data_in.second_cipher = square[ppe_pkg::cell_index(qb)];
         rsp_data_in.final_pair    = pair.final_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/playfair_pair_encryptor_core.sv]
// Playfair pair encryptor top level: square registers, front end, queue, back end.
// Depends on ppe_pkg, ppe_front, ppe_queue, ppe_back and the assertion header.
//
// Takes one letter per cycle while the queue is not full; every second letter
// (or an odd final letter padded with X) yields one cipher pair. The letter
// completing a pair goes through pair forming and square lookup into the
// two-entry queue, then through the cipher rule into the output register that
// drives rsp_valid. The square is held in three write-only registers
// that reset to the KEYWORD square; write them only while no request is in flight.
module playfair_pair_encryptor_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppe_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ppe_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [ppe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [ppe_pkg::FIRST_W-1:0]  cells_first_ff, cells_first_in;
   logic [ppe_pkg::MIDDLE_W-1:0] cells_middle_ff, cells_middle_in;
   logic [ppe_pkg::FINAL_W-1:0]  cells_final_ff, cells_final_in;
   ppe_pkg::square_type          square;

   logic                         req_accept, push, pop;
   ppe_pkg::pair_type            push_data, pop_data;
   ppe_pkg::queue_status_type    q_status;
   ppe_pkg::front_status_type    f_status;

   always_comb begin
      cells_first_in  = cells_first_ff;
      cells_middle_in = cells_middle_ff;
      cells_final_in  = cells_final_ff;
      if (csr_we) begin
         case (ppe_pkg::csr_index_type'(csr_index))
            ppe_pkg::CSR_CELLS_FIRST: begin
               cells_first_in = csr_wdata;
            end
            ppe_pkg::CSR_CELLS_MIDDLE: begin
               cells_middle_in = csr_wdata[ppe_pkg::MIDDLE_W-1:0];
            end
            ppe_pkg::CSR_CELLS_FINAL: begin
               cells_final_in = csr_wdata[ppe_pkg::FINAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_first_ff  <= ppe_pkg::FIRST_RESET;
         cells_middle_ff <= ppe_pkg::MIDDLE_RESET;
         cells_final_ff  <= ppe_pkg::FINAL_RESET;
      end else begin
         cells_first_ff  <= cells_first_in;
         cells_middle_ff <= cells_middle_in;
         cells_final_ff  <= cells_final_in;
      end
   end

   assign square     = {cells_final_ff, cells_middle_ff, cells_first_ff};
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   ppe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .square     (square),
      .push       (push),
      .push_data  (push_data),
      .status     (f_status)
   );

   ppe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   ppe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .square    (square),
      .pair      (pop_data),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`include "playfair_pair_encryptor_core_assert.svh"

   // a final letter always completes a pair and leaves nothing pending
   `PPE_ASSERT_NEXT(a_final_clears_held, clock, reset, req_accept && req_data.end_of_message, !f_status.held_valid)
   `PPE_ASSERT_NEXT(a_final_queued, clock, reset, req_accept && req_data.end_of_message, !q_status.empty)
   `PPE_ASSERT_SAME(a_queue_sane, clock, reset, q_status.full, !q_status.empty)
   `PPE_ASSERT_NEXT(a_pop_loads_rsp, clock, reset, pop, rsp_valid)

endmodule
